// ----- design/drc_pkg.sv -----
// Shared types and constants for the disc and thick line rasterizer.
// No dependencies; every other design file imports this package.
package drc_pkg;

    localparam int COORD_W    = 16;
    localparam int COLOR_W    = 16;
    localparam int RADIUS_MAX = 15;
    // Column index runs up to RADIUS_MAX + 1
    localparam int RAD_W = $clog2(RADIUS_MAX + 2);
    // Signed pixel offset from the disc centre
    localparam int OFF_W = RAD_W + 1;
    // Midpoint decision term
    localparam int DEC_W = RAD_W + 5;

    localparam logic [1:0] FUNC_DISC = 2'd0;
    localparam logic [1:0] FUNC_LINE = 2'd1;
    localparam logic [1:0] FUNC_NEXT = 2'd2;

    typedef struct packed {
        logic [1:0]         func;
        logic [COORD_W-1:0] start_x;
        logic [COORD_W-1:0] start_y;
        logic [COORD_W-1:0] end_x;
        logic [COORD_W-1:0] end_y;
        logic [3:0]         radius;
        logic [COLOR_W-1:0] pen_color;
    } t_in_item;

    typedef struct packed {
        logic [COORD_W-1:0] pixel_x;
        logic [COORD_W-1:0] pixel_y;
        logic [COLOR_W-1:0] pixel_color;
        logic               last;
    } t_out_item;

    // Control from the sequencer to the disc walker
    typedef struct packed {
        logic load;
        logic advance;
    } t_disc_ctrl;

    // Control from the sequencer to the line walker
    typedef struct packed {
        logic start;
        logic step;
    } t_line_ctrl;

    // Clamp the command radius to the supported maximum
    function automatic logic [RAD_W-1:0] sat_radius(input logic [3:0] r);
        logic [RAD_W-1:0] res;
        if (int'(r) > RADIUS_MAX) begin
            res = RAD_W'(RADIUS_MAX);
        end else begin
            res = RAD_W'(r);
        end
        return res;
    endfunction

endpackage

// ----- design/drc_disc.sv -----
// Filled disc walker: midpoint column fill, one pixel per advance.
// Depends on drc_pkg. The cursor always points at the next pixel to emit.
module drc_disc (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    input  drc_pkg::t_disc_ctrl         i_ctrl,
    input  logic [drc_pkg::COORD_W-1:0] i_centre_x,
    input  logic [drc_pkg::COORD_W-1:0] i_centre_y,
    input  logic [drc_pkg::RAD_W-1:0]   i_radius,
    output logic [drc_pkg::COORD_W-1:0] o_pixel_x,
    output logic [drc_pkg::COORD_W-1:0] o_pixel_y,
    output logic                        o_at_centre
);
    import drc_pkg::*;

    typedef enum logic [2:0] {
        ST_COLS   = 3'b001,
        ST_ROWS   = 3'b010,
        ST_CENTRE = 3'b100
    } t_disc_stage;

    localparam logic [2:0] SUB_COL_LAST = 3'd1;
    localparam logic [2:0] SUB_ROW_LAST = 3'd5;

    t_disc_stage              r_stage, n_stage;
    logic [COORD_W-1:0]       r_cx, r_cy, n_cx, n_cy;
    logic [RAD_W-1:0]         r_col_a, r_col_b, r_inner, n_col_a, n_col_b, n_inner;
    logic signed [DEC_W-1:0]  r_dec, n_dec;
    logic [2:0]               r_sub, n_sub;

    logic [RAD_W-1:0]         w_a1;
    logic signed [DEC_W-1:0]  w_a1x4, w_bx4, w_dec_adv;
    logic signed [OFF_W-1:0]  w_a1_s, w_b_s, w_b1_s;
    logic signed [OFF_W-1:0]  w_pa, w_pb, w_pp, w_off_x, w_off_y;

    // Column advance: midpoint decision update
    always_comb begin
        w_a1   = r_col_a + 1'b1;
        w_a1x4 = DEC_W'({w_a1, 2'b00});
        w_bx4  = DEC_W'({r_col_b, 2'b00});
        w_a1_s = signed'({1'b0, w_a1});
        w_b_s  = signed'({1'b0, r_col_b});
        if (r_dec < 0) begin
            w_dec_adv = r_dec + w_a1x4 + DEC_W'(6);
            w_b1_s    = w_b_s;
        end else begin
            w_dec_adv = r_dec + DEC_W'(10) + w_a1x4 - w_bx4;
            w_b1_s    = w_b_s - OFF_W'(1);
        end
    end

    // Next cursor
    always_comb begin
        n_stage = r_stage;
        n_cx    = r_cx;
        n_cy    = r_cy;
        n_col_a = r_col_a;
        n_col_b = r_col_b;
        n_inner = r_inner;
        n_dec   = r_dec;
        n_sub   = r_sub;
        if (i_ctrl.load) begin
            n_cx    = i_centre_x;
            n_cy    = i_centre_y;
            n_col_a = '0;
            n_col_b = i_radius;
            n_inner = i_radius;
            n_dec   = DEC_W'(3) - DEC_W'({i_radius, 1'b0});
            n_sub   = '0;
            n_stage = (i_radius != '0) ? ST_ROWS : ST_CENTRE;
        end else if (i_ctrl.advance) begin
            case (r_stage)
                ST_COLS: begin
                    if (r_sub != SUB_COL_LAST) begin
                        n_sub = r_sub + 3'd1;
                    end else begin
                        n_sub = '0;
                        if (r_inner > RAD_W'(1)) begin
                            n_inner = r_inner - 1'b1;
                        end else begin
                            n_inner = r_col_b;
                            n_stage = ST_ROWS;
                        end
                    end
                end
                ST_ROWS: begin
                    if (r_sub != SUB_ROW_LAST) begin
                        n_sub = r_sub + 3'd1;
                    end else begin
                        n_sub = '0;
                        if (r_inner > RAD_W'(1)) begin
                            n_inner = r_inner - 1'b1;
                        end else begin
                            n_col_a = w_a1;
                            n_col_b = w_b1_s[RAD_W-1:0];
                            n_dec   = w_dec_adv;
                            n_inner = w_a1;
                            n_stage = (w_a1_s <= w_b1_s) ? ST_COLS : ST_CENTRE;
                        end
                    end
                end
                default: begin
                    n_stage = ST_CENTRE;
                end
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_stage <= ST_CENTRE;
            r_cx    <= '0;
            r_cy    <= '0;
            r_col_a <= '0;
            r_col_b <= '0;
            r_inner <= '0;
            r_dec   <= '0;
            r_sub   <= '0;
        end else begin
            r_stage <= n_stage;
            r_cx    <= n_cx;
            r_cy    <= n_cy;
            r_col_a <= n_col_a;
            r_col_b <= n_col_b;
            r_inner <= n_inner;
            r_dec   <= n_dec;
            r_sub   <= n_sub;
        end
    end

    // Pixel offset for the current cursor
    always_comb begin
        w_pa    = signed'({1'b0, r_col_a});
        w_pb    = signed'({1'b0, r_col_b});
        w_pp    = signed'({1'b0, r_inner});
        w_off_x = '0;
        w_off_y = '0;
        case (r_stage)
            ST_COLS: begin
                if (r_sub == '0) begin
                    w_off_x = w_pb;
                    w_off_y = -w_pp;
                end else begin
                    w_off_x = -w_pp;
                    w_off_y = w_pb;
                end
            end
            ST_ROWS: begin
                case (r_sub)
                    3'd0: begin w_off_x = -w_pa; w_off_y = -w_pp; end
                    3'd1: begin w_off_x = -w_pp; w_off_y = -w_pa; end
                    3'd2: begin w_off_x = w_pa;  w_off_y = -w_pp; end
                    3'd3: begin w_off_x = -w_pp; w_off_y = w_pa;  end
                    3'd4: begin w_off_x = w_pa;  w_off_y = w_pp;  end
                    default: begin w_off_x = w_pp; w_off_y = w_pa; end
                endcase
            end
            default: begin
                w_off_x = '0;
                w_off_y = '0;
            end
        endcase
    end

    assign o_pixel_x   = r_cx + COORD_W'(w_off_x);
    assign o_pixel_y   = r_cy + COORD_W'(w_off_y);
    assign o_at_centre = (r_stage == ST_CENTRE);

    // A column or row cursor always has a pixel left to emit
    a_inner_live: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_stage != ST_CENTRE) |-> (r_inner != '0))
        else $error("disc cursor parked on an empty column");

    a_sub_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_stage == ST_COLS) |-> (r_sub <= SUB_COL_LAST))
        else $error("column sub-phase out of range");

endmodule

// ----- design/drc_line.sv -----
// Thick line walker: error accumulation along the major axis.
// Depends on drc_pkg. Supplies the centre of each stamped disc.
module drc_line (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    input  drc_pkg::t_line_ctrl         i_ctrl,
    input  logic [drc_pkg::COORD_W-1:0] i_start_x,
    input  logic [drc_pkg::COORD_W-1:0] i_start_y,
    input  logic [drc_pkg::COORD_W-1:0] i_end_x,
    input  logic [drc_pkg::COORD_W-1:0] i_end_y,
    output logic [drc_pkg::COORD_W-1:0] o_next_x,
    output logic [drc_pkg::COORD_W-1:0] o_next_y,
    output logic                        o_final
);
    import drc_pkg::*;

    logic [COORD_W-1:0] r_x, r_y, r_dx_abs, r_dy_abs, r_major;
    logic [COORD_W:0]   r_err_x, r_err_y, r_steps;
    logic [3:0]         r_signs;

    logic [COORD_W:0]   w_dx, w_dy, w_sum_x, w_sum_y, w_major_ext;
    logic [COORD_W-1:0] w_abs_x, w_abs_y, w_step_x, w_step_y;
    logic [3:0]         w_signs;
    logic               w_move_x, w_move_y;

    // Deltas and directions of a new line
    always_comb begin
        w_dx    = {1'b0, i_end_x} - {1'b0, i_start_x};
        w_dy    = {1'b0, i_end_y} - {1'b0, i_start_y};
        w_abs_x = w_dx[COORD_W] ? COORD_W'(-w_dx) : w_dx[COORD_W-1:0];
        w_abs_y = w_dy[COORD_W] ? COORD_W'(-w_dy) : w_dy[COORD_W-1:0];
        w_signs = '0;
        if (w_dx[COORD_W]) begin
            w_signs[1:0] = 2'b11;
        end else if (w_dx != '0) begin
            w_signs[1:0] = 2'b01;
        end
        if (w_dy[COORD_W]) begin
            w_signs[3:2] = 2'b11;
        end else if (w_dy != '0) begin
            w_signs[3:2] = 2'b01;
        end
    end

    // One step along the line
    always_comb begin
        w_major_ext = {1'b0, r_major};
        w_sum_x     = r_err_x + {1'b0, r_dx_abs};
        w_sum_y     = r_err_y + {1'b0, r_dy_abs};
        w_move_x    = (w_sum_x > w_major_ext);
        w_move_y    = (w_sum_y > w_major_ext);
        w_step_x    = r_signs[1] ? '1 : COORD_W'(r_signs[0]);
        w_step_y    = r_signs[3] ? '1 : COORD_W'(r_signs[2]);
        o_next_x    = w_move_x ? (r_x + w_step_x) : r_x;
        o_next_y    = w_move_y ? (r_y + w_step_y) : r_y;
        o_final     = (r_steps >= (w_major_ext + 1'b1));
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_x      <= '0;
            r_y      <= '0;
            r_dx_abs <= '0;
            r_dy_abs <= '0;
            r_major  <= '0;
            r_err_x  <= '0;
            r_err_y  <= '0;
            r_steps  <= '0;
            r_signs  <= '0;
        end else if (i_ctrl.start) begin
            r_x      <= i_start_x;
            r_y      <= i_start_y;
            r_dx_abs <= w_abs_x;
            r_dy_abs <= w_abs_y;
            r_major  <= (w_abs_x > w_abs_y) ? w_abs_x : w_abs_y;
            r_err_x  <= '0;
            r_err_y  <= '0;
            r_steps  <= '0;
            r_signs  <= w_signs;
        end else if (i_ctrl.step) begin
            r_x     <= o_next_x;
            r_y     <= o_next_y;
            r_err_x <= w_move_x ? (w_sum_x - w_major_ext) : w_sum_x;
            r_err_y <= w_move_y ? (w_sum_y - w_major_ext) : w_sum_y;
            r_steps <= r_steps + 1'b1;
        end
    end

    // Error terms never pass the major distance
    a_err_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_err_x <= {1'b0, r_major}) && (r_err_y <= {1'b0, r_major}))
        else $error("line error term above major distance");

endmodule

// ----- design/disc_and_thick_line_rasterizer.sv -----
// Disc and thick line rasterizer. A start item (disc or line) gives no pixel; each later
// next item gives exactly one pixel, registered in the cycle after it is accepted, so one
// item per clock is sustained as long as the output side takes results. The rate is set by
// the cursor update in the disc walker and the line stepper, whose results are
// held in one output register; the input is ready whenever that register is empty or being
// taken. Discs end on their centre pixel; lines stamp major distance + 2 discs. A start
// abandons any command in progress; next items given while idle are taken and dropped.
// Depends on drc_pkg, drc_disc and drc_line.
module disc_and_thick_line_rasterizer (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_in_valid,
    output logic               o_in_ready,
    input  drc_pkg::t_in_item  i_in_data,
    output logic               o_out_valid,
    input  logic               i_out_ready,
    output drc_pkg::t_out_item o_out_data
);
    import drc_pkg::*;

    typedef enum logic [2:0] {
        MODE_IDLE = 3'b001,
        MODE_DISC = 3'b010,
        MODE_LINE = 3'b100
    } t_mode;

    t_mode              r_mode, n_mode;
    logic [RAD_W-1:0]   r_radius;
    logic [COLOR_W-1:0] r_color;
    logic               r_out_valid;
    t_out_item          r_out_data;

    logic               w_fire, w_start, w_emit, w_last, w_line_next;
    logic [RAD_W-1:0]   w_radius;
    logic [COORD_W-1:0] w_pix_x, w_pix_y, w_line_x, w_line_y;
    logic               w_at_centre, w_line_final;
    t_disc_ctrl         w_disc_ctrl;
    t_line_ctrl         w_line_ctrl;

    // Decode the transfer
    always_comb begin
        w_fire      = i_in_valid && o_in_ready;
        w_start     = w_fire && ((i_in_data.func == FUNC_DISC) ||
                                 (i_in_data.func == FUNC_LINE));
        w_emit      = w_fire && (i_in_data.func == FUNC_NEXT) && (r_mode != MODE_IDLE);
        w_last      = w_at_centre && ((r_mode == MODE_DISC) || w_line_final);
        w_line_next = w_emit && w_at_centre && (r_mode == MODE_LINE) && !w_line_final;
        w_radius    = w_start ? sat_radius(i_in_data.radius) : r_radius;

        w_disc_ctrl.load    = w_start || w_line_next;
        w_disc_ctrl.advance = w_emit;
        w_line_ctrl.start   = w_fire && (i_in_data.func == FUNC_LINE);
        w_line_ctrl.step    = w_line_next;
    end

    drc_disc u_disc (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_ctrl      (w_disc_ctrl),
        .i_centre_x  (w_start ? i_in_data.start_x : w_line_x),
        .i_centre_y  (w_start ? i_in_data.start_y : w_line_y),
        .i_radius    (w_radius),
        .o_pixel_x   (w_pix_x),
        .o_pixel_y   (w_pix_y),
        .o_at_centre (w_at_centre)
    );

    drc_line u_line (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_ctrl    (w_line_ctrl),
        .i_start_x (i_in_data.start_x),
        .i_start_y (i_in_data.start_y),
        .i_end_x   (i_in_data.end_x),
        .i_end_y   (i_in_data.end_y),
        .o_next_x  (w_line_x),
        .o_next_y  (w_line_y),
        .o_final   (w_line_final)
    );

    // Command mode
    always_comb begin
        n_mode = r_mode;
        if (w_start) begin
            n_mode = (i_in_data.func == FUNC_LINE) ? MODE_LINE : MODE_DISC;
        end else if (w_emit && w_last) begin
            n_mode = MODE_IDLE;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_mode   <= MODE_IDLE;
            r_radius <= '0;
            r_color  <= '0;
        end else begin
            r_mode <= n_mode;
            if (w_start) begin
                r_radius <= w_radius;
                r_color  <= i_in_data.pen_color;
            end
        end
    end

    // Result register: load on a pixel, drop once taken
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (w_emit) begin
            r_out_valid <= 1'b1;
        end else if (i_out_ready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_emit) begin
            r_out_data.pixel_x     <= w_pix_x;
            r_out_data.pixel_y     <= w_pix_y;
            r_out_data.pixel_color <= r_color;
            r_out_data.last        <= w_last;
        end
    end

    assign o_in_ready  = !r_out_valid || i_out_ready;
    assign o_out_valid = r_out_valid;
    assign o_out_data  = r_out_data;

    // A served pixel always shows up in the result register
    a_emit_shows: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_emit |=> o_out_valid)
        else $error("pixel transfer lost");

    // The final pixel of a command leaves the block idle
    a_last_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (w_emit && w_last) |=> (r_mode == MODE_IDLE))
        else $error("command still active after its last pixel");

endmodule
